// ===== src/sswc_pkg.sv =====
// Package with the shared types and constants of the speed-sensitive wiper controller.
package sswc_pkg;

   typedef enum logic [2:0] {
      WIPER_OFF      = 3'd0,
      WIPER_INTERVAL = 3'd1,
      WIPER_SLOW     = 3'd2,
      WIPER_FAST     = 3'd3,
      WIPER_AUTO     = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_SET_MODE = 2'd1,
      OP_SINGLE_WIPE = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_SENSITIVITY = 3'd0,
      REG_SPEED_ENABLE = 3'd1,
      REG_LOW_SPEED = 3'd2,
      REG_HIGH_SPEED = 3'd3,
      REG_WIPE_MS = 3'd4
   } reg_index_type;

   localparam logic [6:0] SENS_MAX = 7'd100;
   localparam logic [6:0] DELAY_UNITS = 7'd125;
   localparam logic [12:0] UNIT_BASE = 13'd40;
   localparam logic [12:0] UNIT_SLOW = 13'd60;
   localparam logic [12:0] UNIT_FAST = 13'd28;
   localparam logic [12:0] WAIT_CLAMP = 13'd7500;

   typedef struct packed {
      logic [6:0]  sensitivity_pct;
      logic        speed_sensitive_enable;
      logic [9:0]  low_speed_kmh;
      logic [9:0]  high_speed_kmh;
      logic [15:0] wipe_ms;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic        relay_active;
      logic [31:0] last_wipe_at;
      logic [31:0] next_wipe_at;
      logic [9:0]  speed_seen;
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_ms;
      logic [9:0]  road_speed;
      logic [2:0]  new_mode;
   } item_type;

endpackage

// ===== src/speed_sensitive_wiper_controller.sv =====
// Top level of the speed-sensitive wiper controller with stream and register ports.
//
// Channel  Direction  Transfer                     Contents
// req      in         req_tvalid & req_tready      operation (tuser); now_ms, road_speed, new_mode
// rsp      out        rsp_tvalid & rsp_tready      relay_on, wait_ms
// csr      in/out     psel & penable & pwrite      five control registers at 4*i
//
// The controller state and the result register are
// written at the edge that accepts the item, and the result is offered in the next cycle.
// A new item is accepted while the result register is empty or being taken.
// Reset is synchronous and restores the register defaults and the off mode.
// A stalled result holds its value until it is taken.
module speed_sensitive_wiper_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms[31:0], road_speed[41:32], new_mode[44:42], zero fill
   input  logic [47:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // relay_on[0], wait_ms[13:1], zero fill
   output logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   sswc_pkg::cfg_type   cfg_ff, cfg_in;
   sswc_pkg::state_type state_ff, state_in;
   sswc_pkg::state_type state_calc;
   sswc_pkg::item_type  item;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                relay_ff, relay_in;
   logic [12:0]         wait_ff, wait_in;
   logic                relay_calc;
   logic [12:0]         wait_calc;
   logic                req_accept;
   logic                csr_write;
   logic [6:0]          sens_wr;

   assign item.operation  = req_tuser;
   assign item.now_ms     = req_tdata[31:0];
   assign item.road_speed = req_tdata[41:32];
   assign item.new_mode   = req_tdata[44:42];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, wait_ff, relay_ff};
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign sens_wr    = csr_pwdata[6:0];

   sswc_core u_core (
      .item       (item),
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .state_next (state_calc),
      .relay_on   (relay_calc),
      .wait_ms    (wait_calc)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:2])
            sswc_pkg::REG_SENSITIVITY: begin
               cfg_in.sensitivity_pct = (sens_wr > sswc_pkg::SENS_MAX) ?
                                        sswc_pkg::SENS_MAX : sens_wr;
            end
            sswc_pkg::REG_SPEED_ENABLE: cfg_in.speed_sensitive_enable = csr_pwdata[0];
            sswc_pkg::REG_LOW_SPEED:    cfg_in.low_speed_kmh = csr_pwdata[9:0];
            sswc_pkg::REG_HIGH_SPEED:   cfg_in.high_speed_kmh = csr_pwdata[9:0];
            sswc_pkg::REG_WIPE_MS:      cfg_in.wipe_ms = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         sswc_pkg::REG_SENSITIVITY:  csr_prdata = {25'd0, cfg_ff.sensitivity_pct};
         sswc_pkg::REG_SPEED_ENABLE: csr_prdata = {31'd0, cfg_ff.speed_sensitive_enable};
         sswc_pkg::REG_LOW_SPEED:    csr_prdata = {22'd0, cfg_ff.low_speed_kmh};
         sswc_pkg::REG_HIGH_SPEED:   csr_prdata = {22'd0, cfg_ff.high_speed_kmh};
         sswc_pkg::REG_WIPE_MS:      csr_prdata = {16'd0, cfg_ff.wipe_ms};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      state_in     = req_accept ? state_calc : state_ff;
      relay_in     = req_accept ? relay_calc : relay_ff;
      wait_in      = req_accept ? wait_calc : wait_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensitivity_pct        <= 7'd50;
         cfg_ff.speed_sensitive_enable <= 1'b1;
         cfg_ff.low_speed_kmh          <= 10'd30;
         cfg_ff.high_speed_kmh         <= 10'd80;
         cfg_ff.wipe_ms                <= 16'd500;
         state_ff.mode                 <= sswc_pkg::WIPER_OFF;
         state_ff.relay_active         <= 1'b0;
         state_ff.last_wipe_at         <= 32'd0;
         state_ff.next_wipe_at         <= 32'd0;
         state_ff.speed_seen           <= 10'd0;
         rsp_valid_ff                  <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      relay_ff <= relay_in;
      wait_ff  <= wait_in;
   end

endmodule

// ===== src/sswc_core.sv =====
// Combinational next-state and result logic for one wiper controller item.
module sswc_core (
   input  sswc_pkg::item_type  item,
   input  sswc_pkg::cfg_type   cfg,
   input  sswc_pkg::state_type state_cur,
   output sswc_pkg::state_type state_next,
   output logic                relay_on,
   output logic [12:0]         wait_ms
);

   logic [9:0]  speed_use;
   logic [6:0]  units;
   logic [12:0] unit_ms;
   logic [12:0] delay_ms;
   logic [31:0] since_next;
   logic        next_reached;
   logic [31:0] since_last;
   logic        pulse_done;
   logic        wipe_now_done;
   logic [31:0] remaining;
   logic [31:0] overdue;

   always_comb begin
      speed_use = (sswc_pkg::op_type'(item.operation) == sswc_pkg::OP_UPDATE) ?
                  item.road_speed : state_cur.speed_seen;
      units = sswc_pkg::DELAY_UNITS - cfg.sensitivity_pct;
      unit_ms = sswc_pkg::UNIT_BASE;
      if (cfg.speed_sensitive_enable) begin
         if (speed_use < cfg.low_speed_kmh) begin
            unit_ms = sswc_pkg::UNIT_SLOW;
         end else if (speed_use > cfg.high_speed_kmh) begin
            unit_ms = sswc_pkg::UNIT_FAST;
         end
      end
      delay_ms = {6'd0, units} * unit_ms;
      since_next = item.now_ms - state_cur.next_wipe_at;
      next_reached = !since_next[31];
      since_last = item.now_ms - state_cur.last_wipe_at;
      pulse_done = since_last >= {16'd0, cfg.wipe_ms};
      wipe_now_done = cfg.wipe_ms == 16'd0;

      state_next = state_cur;
      unique case (sswc_pkg::op_type'(item.operation))
         sswc_pkg::OP_UPDATE: begin
            state_next.speed_seen = item.road_speed;
            unique case (state_cur.mode)
               sswc_pkg::WIPER_OFF: begin
                  state_next.relay_active = 1'b0;
               end
               sswc_pkg::WIPER_INTERVAL: begin
                  if (!state_cur.relay_active) begin
                     if (next_reached) begin
                        state_next.relay_active = 1'b1;
                        state_next.next_wipe_at = item.now_ms + {19'd0, delay_ms};
                        state_next.last_wipe_at = item.now_ms;
                     end
                  end else if (pulse_done) begin
                     state_next.relay_active = 1'b0;
                  end
               end
               sswc_pkg::WIPER_SLOW: begin
                  if (pulse_done) begin
                     state_next.relay_active = !state_cur.relay_active;
                     state_next.last_wipe_at = item.now_ms;
                  end
               end
               sswc_pkg::WIPER_FAST: begin
                  state_next.relay_active = 1'b1;
               end
               sswc_pkg::WIPER_AUTO: begin
                  if (next_reached) begin
                     state_next.next_wipe_at = item.now_ms + {19'd0, delay_ms};
                     state_next.last_wipe_at = item.now_ms;
                     state_next.relay_active = !wipe_now_done;
                  end else if (state_cur.relay_active && pulse_done) begin
                     state_next.relay_active = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         sswc_pkg::OP_SET_MODE: begin
            if (item.new_mode <= sswc_pkg::WIPER_AUTO) begin
               state_next.mode = sswc_pkg::mode_type'(item.new_mode);
               if (sswc_pkg::mode_type'(item.new_mode) == sswc_pkg::WIPER_INTERVAL) begin
                  state_next.next_wipe_at = item.now_ms + {19'd0, delay_ms};
               end
            end
         end
         sswc_pkg::OP_SINGLE_WIPE: begin
            if (!state_cur.relay_active) begin
               state_next.relay_active = 1'b1;
               state_next.last_wipe_at = item.now_ms;
            end
         end
         sswc_pkg::OP_NONE: begin
         end
      endcase

      remaining = state_next.next_wipe_at - item.now_ms;
      overdue = item.now_ms - state_next.next_wipe_at;
      wait_ms = 13'd0;
      if (state_next.mode == sswc_pkg::WIPER_INTERVAL && overdue[31]) begin
         if (remaining > {19'd0, sswc_pkg::WAIT_CLAMP}) begin
            wait_ms = sswc_pkg::WAIT_CLAMP;
         end else begin
            wait_ms = remaining[12:0];
         end
      end
      relay_on = state_next.relay_active;
   end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the speed-sensitive wiper controller.
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      logic        relay_on;
      logic [12:0] wait_ms;
   } wiper_status_type;

   localparam logic [2:0] MODE_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] MODE_UNKNOWN_HI = 3'd7;
   localparam int HOLD_AFTER_ITEMS = 300;
   localparam int HOLD_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   speed_sensitive_wiper_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Controller copy used for prediction.
   logic [6:0]         sens_cfg = 7'd50;
   logic               speed_scale_cfg = 1'b1;
   logic [9:0]         low_kmh_cfg = 10'd30;
   logic [9:0]         high_kmh_cfg = 10'd80;
   logic [15:0]        wipe_cfg = 16'd500;
   sswc_pkg::mode_type mode_now = sswc_pkg::WIPER_OFF;
   logic               relay_now = 1'b0;
   logic [31:0]        last_wipe_ms = '0;
   logic [31:0]        next_wipe_ms = '0;
   logic [9:0]         speed_now = '0;

   sswc_pkg::item_type req_backlog[$];
   wiper_status_type   expected_wiper[$];

   bit          req_taken = 1'b0;
   int          items_issued = 0;
   int          items_accepted = 0;
   int          results_seen = 0;
   int          failures = 0;
   int          idle_chance = 0;
   logic [3:0]  send_gap = '0;
   logic [3:0]  stall_left = '0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   logic [31:0] stamp_ms = '0;
   logic [9:0]  speed_kmh = '0;

   function automatic logic time_reached(logic [31:0] now, logic [31:0] mark);
      logic [31:0] diff;
      diff = now - mark;
      return !diff[31];
   endfunction

   function automatic logic [31:0] wipe_delay_ms();
      logic [31:0] d;
      d = 32'd5000 - 32'd40 * sens_cfg;
      if (speed_scale_cfg) begin
         if (speed_now < low_kmh_cfg) d = d * 3 / 2;
         else if (speed_now > high_kmh_cfg) d = d * 7 / 10;
      end
      return d;
   endfunction

   function automatic logic pulse_over(logic [31:0] now);
      logic [31:0] span;
      span = now - last_wipe_ms;
      return span >= {16'd0, wipe_cfg};
   endfunction

   function automatic void arm_wipe(logic [31:0] now);
      if (time_reached(now, next_wipe_ms)) begin
         relay_now = 1'b1;
         next_wipe_ms = now + wipe_delay_ms();
         last_wipe_ms = now;
      end
   endfunction

   function automatic wiper_status_type predict_wiper(sswc_pkg::item_type it);
      wiper_status_type res;
      logic [31:0] w;
      w = '0;
      case (sswc_pkg::op_type'(it.operation))
         sswc_pkg::OP_UPDATE: begin
            speed_now = it.road_speed;
            case (mode_now)
               sswc_pkg::WIPER_OFF: relay_now = 1'b0;
               sswc_pkg::WIPER_INTERVAL: begin
                  if (!relay_now) arm_wipe(it.now_ms);
                  else if (pulse_over(it.now_ms)) relay_now = 1'b0;
               end
               sswc_pkg::WIPER_SLOW: begin
                  if (pulse_over(it.now_ms)) begin
                     relay_now = !relay_now;
                     last_wipe_ms = it.now_ms;
                  end
               end
               sswc_pkg::WIPER_FAST: relay_now = 1'b1;
               sswc_pkg::WIPER_AUTO: begin
                  arm_wipe(it.now_ms);
                  if (relay_now && pulse_over(it.now_ms)) relay_now = 1'b0;
               end
               default: ;
            endcase
         end
         sswc_pkg::OP_SET_MODE: begin
            if (it.new_mode <= sswc_pkg::WIPER_AUTO) begin
               mode_now = sswc_pkg::mode_type'(it.new_mode);
               if (mode_now == sswc_pkg::WIPER_INTERVAL)
                  next_wipe_ms = it.now_ms + wipe_delay_ms();
            end
         end
         sswc_pkg::OP_SINGLE_WIPE: begin
            if (!relay_now) begin
               relay_now = 1'b1;
               last_wipe_ms = it.now_ms;
            end
         end
         default: ;
      endcase
      if (mode_now == sswc_pkg::WIPER_INTERVAL && !time_reached(it.now_ms, next_wipe_ms)) begin
         w = next_wipe_ms - it.now_ms;
         if (w > sswc_pkg::WAIT_CLAMP) w = sswc_pkg::WAIT_CLAMP;
      end
      res.relay_on = relay_now;
      res.wait_ms = w[12:0];
      return res;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // Request driver.
   always @(negedge clock) begin
      sswc_pkg::item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
      end else if (send_gap != 0) begin
         send_gap <= send_gap - 1'b1;
         req_tvalid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
         it = req_backlog.pop_front();
         req_tdata <= {3'b000, it.new_mode, it.road_speed, it.now_ms};
         req_tuser <= it.operation;
         req_tvalid <= 1'b1;
         if ($urandom_range(0, 15) < idle_chance) send_gap <= 4'($urandom_range(1, 12));
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result receiver with short random stalls.
   always @(negedge clock) begin
      if (reset || hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 15) < idle_chance) stall_left <= 4'($urandom_range(1, 12));
      end
   end

   // One long hold-off on the result side so that the input backs up.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_accepted >= HOLD_AFTER_ITEMS) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Monitor: predicts on each request transfer and checks each result transfer.
   always @(posedge clock) begin
      sswc_pkg::item_type it;
      wiper_status_type   got;
      wiper_status_type   want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.relay_on = rsp_tdata[0];
            got.wait_ms = rsp_tdata[13:1];
            if (expected_wiper.size() == 0) begin
               $display("%0t: unexpected result relay %0d wait %0d", $time,
                        got.relay_on, got.wait_ms);
               failures++;
            end else begin
               want = expected_wiper.pop_front();
               if (got.relay_on !== want.relay_on || got.wait_ms !== want.wait_ms) begin
                  $display("%0t: expected relay %0d wait %0d, actual relay %0d wait %0d",
                           $time, want.relay_on, want.wait_ms, got.relay_on, got.wait_ms);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            items_accepted++;
            it.operation = req_tuser;
            it.now_ms = req_tdata[31:0];
            it.road_speed = req_tdata[41:32];
            it.new_mode = req_tdata[44:42];
            expected_wiper.push_back(predict_wiper(it));
         end
      end
   end

   task automatic write_register(sswc_pkg::reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         sswc_pkg::REG_SENSITIVITY:
            sens_cfg = value[6:0] > sswc_pkg::SENS_MAX ? sswc_pkg::SENS_MAX : value[6:0];
         sswc_pkg::REG_SPEED_ENABLE: speed_scale_cfg = value[0];
         sswc_pkg::REG_LOW_SPEED: low_kmh_cfg = value[9:0];
         sswc_pkg::REG_HIGH_SPEED: high_kmh_cfg = value[9:0];
         sswc_pkg::REG_WIPE_MS: wipe_cfg = value[15:0];
         default: ;
      endcase
   endtask

   task automatic queue_item(sswc_pkg::op_type op, logic [31:0] now, logic [9:0] speed,
                             logic [2:0] nm);
      sswc_pkg::item_type it;
      it.operation = op;
      it.now_ms = now;
      it.road_speed = speed;
      it.new_mode = nm;
      req_backlog.push_back(it);
      items_issued++;
   endtask

   // Mostly a clock that moves forward at a plausible pace, with jumps and noise.
   task automatic queue_random_traffic(int count);
      int r;
      logic [2:0] nm;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3) stamp_ms = $urandom;
         else if (r < 5) stamp_ms = stamp_ms - $urandom_range(1, 9000);
         else if (r >= 8) begin
            if ($urandom_range(0, 9) == 0) stamp_ms = stamp_ms + $urandom_range(0, 9000);
            else stamp_ms = stamp_ms + $urandom_range(0, 400);
         end
         if ($urandom_range(0, 7) == 0) speed_kmh = 10'($urandom_range(0, 1023));
         r = $urandom_range(0, 99);
         if (r < 80) begin
            queue_item(sswc_pkg::OP_UPDATE, stamp_ms, speed_kmh, 3'($urandom));
         end else if (r < 90) begin
            if ($urandom_range(0, 19) == 0)
               nm = 3'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
            else
               nm = 3'($urandom_range(sswc_pkg::WIPER_OFF, sswc_pkg::WIPER_AUTO));
            queue_item(sswc_pkg::OP_SET_MODE, stamp_ms, 10'($urandom), nm);
         end else if (r < 97) begin
            queue_item(sswc_pkg::OP_SINGLE_WIPE, stamp_ms, 10'($urandom), 3'($urandom));
         end else begin
            queue_item(sswc_pkg::OP_NONE, stamp_ms, 10'($urandom), 3'($urandom));
         end
      end
   endtask

   task automatic drain();
      while (results_seen != items_issued) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      idle_chance = 3;
      queue_item(sswc_pkg::OP_UPDATE, 32'd0, 10'd0, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_SET_MODE, 32'd100, 10'd0, sswc_pkg::WIPER_INTERVAL);
      queue_item(sswc_pkg::OP_UPDATE, 32'd1000, 10'd1023, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_UPDATE, 32'd4600, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_UPDATE, 32'd5100, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_SINGLE_WIPE, 32'd5200, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_SINGLE_WIPE, 32'd5300, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_SET_MODE, 32'd5400, 10'd50, MODE_UNKNOWN_LO);
      queue_item(sswc_pkg::OP_SET_MODE, 32'd5400, 10'd50, MODE_UNKNOWN_HI);
      queue_item(sswc_pkg::OP_NONE, 32'd5500, 10'd1023, MODE_UNKNOWN_HI);
      queue_item(sswc_pkg::OP_SET_MODE, 32'd6000, 10'd50, sswc_pkg::WIPER_SLOW);
      queue_item(sswc_pkg::OP_UPDATE, 32'd6000, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_UPDATE, 32'd6300, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_UPDATE, 32'd6500, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_UPDATE, 32'd7000, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_SET_MODE, 32'd7100, 10'd50, sswc_pkg::WIPER_FAST);
      queue_item(sswc_pkg::OP_UPDATE, 32'd7200, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_SET_MODE, 32'd7300, 10'd50, sswc_pkg::WIPER_AUTO);
      queue_item(sswc_pkg::OP_UPDATE, 32'd7600, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_UPDATE, 32'd8200, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_SET_MODE, 32'd8300, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_UPDATE, 32'd8400, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_SET_MODE, 32'hFFFF_FF00, 10'd50, sswc_pkg::WIPER_INTERVAL);
      queue_item(sswc_pkg::OP_UPDATE, 32'h0000_0100, 10'd50, sswc_pkg::WIPER_OFF);
      queue_item(sswc_pkg::OP_UPDATE, 32'hFFFF_FFFF, 10'd1023, MODE_UNKNOWN_HI);
      queue_item(sswc_pkg::OP_NONE, 32'hFFFF_D000, 10'd0, sswc_pkg::WIPER_OFF);
      stamp_ms = 32'd10000;
      queue_random_traffic(100);
      drain();

      for (int p = 1; p <= 8; p++) begin
         case (p)
            1: begin
               write_register(sswc_pkg::REG_SENSITIVITY, 32'd0);
               write_register(sswc_pkg::REG_SPEED_ENABLE, 32'd1);
               write_register(sswc_pkg::REG_LOW_SPEED, 32'd0);
               write_register(sswc_pkg::REG_HIGH_SPEED, 32'd1023);
               write_register(sswc_pkg::REG_WIPE_MS, 32'd1);
            end
            2: begin
               write_register(sswc_pkg::REG_SENSITIVITY, 32'd100);
               write_register(sswc_pkg::REG_SPEED_ENABLE, 32'd0);
               write_register(sswc_pkg::REG_LOW_SPEED, 32'd1023);
               write_register(sswc_pkg::REG_HIGH_SPEED, 32'd0);
               write_register(sswc_pkg::REG_WIPE_MS, 32'd65535);
            end
            3: begin
               write_register(sswc_pkg::REG_SENSITIVITY, 32'd127);
               write_register(sswc_pkg::REG_SPEED_ENABLE, 32'd1);
               write_register(sswc_pkg::REG_LOW_SPEED, 32'd1023);
               write_register(sswc_pkg::REG_HIGH_SPEED, 32'd0);
               write_register(sswc_pkg::REG_WIPE_MS, 32'd300);
               stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            end
            default: begin
               write_register(sswc_pkg::REG_SENSITIVITY, $urandom_range(0, 127));
               write_register(sswc_pkg::REG_SPEED_ENABLE, $urandom_range(0, 1));
               write_register(sswc_pkg::REG_LOW_SPEED, $urandom_range(0, 1023));
               write_register(sswc_pkg::REG_HIGH_SPEED, $urandom_range(0, 1023));
               write_register(sswc_pkg::REG_WIPE_MS, $urandom_range(1, 1500));
            end
         endcase
         @(posedge clock);
         idle_chance = (p == 8) ? 0 : $urandom_range(0, 5);
         queue_random_traffic(110);
         drain();
      end

      if (expected_wiper.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_wiper.size());
         failures++;
      end
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
src/sswc_pkg.sv
src/sswc_core.sv
src/speed_sensitive_wiper_controller.sv
sim/tb.sv
